[design/refcounted_compacting_allocator_top_defines.svh]
// Assertion macros used by the allocator top module.
`ifndef REFCOUNTED_COMPACTING_ALLOCATOR_TOP_DEFINES_SVH
`define REFCOUNTED_COMPACTING_ALLOCATOR_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RCA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("allocator assertion failed");
`define RCA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("allocator assertion failed");
`else
`define RCA_ASSERT_IMP(lbl, ante, cons)
`define RCA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[design/rca_pkg.sv]
package rca_pkg;
    localparam int MEM_BYTES   = 4096;
    localparam int HANDLE_BITS = 16;
    localparam int ADDR_W      = 12;
    localparam int SIZE_W      = 12;
    localparam int REFS_W      = 16;
    localparam int ALU_W       = 17;
    localparam logic [REFS_W-1:0] REFS_MAX = '1;

    localparam logic [1:0] REQ_INSERT   = 2'd0;
    localparam logic [1:0] REQ_RETRIEVE = 2'd1;
    localparam logic [1:0] REQ_ADD      = 2'd2;
    localparam logic [1:0] REQ_DROP     = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MEM_FULL  = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_EXHAUSTED = 2'd3;

    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    typedef struct packed {
        logic [1:0]             req_type;
        logic [SIZE_W-1:0]      size;
        logic [HANDLE_BITS-1:0] handle;
    } req_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [HANDLE_BITS-1:0] new_handle;
        logic [ADDR_W-1:0]      address;
        logic                   region;
        logic                   compacted;
        logic [6:0]             live_objects;
        logic [ADDR_W-1:0]      free_index;
    } rsp_t;

    typedef struct packed {
        logic [HANDLE_BITS-1:0] handle;
        logic [ADDR_W-1:0]      start;
        logic [SIZE_W-1:0]      size;
        logic [REFS_W-1:0]      refs;
    } slot_entry_t;

    typedef struct packed {
        logic             op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_ctl_t;
endpackage

[design/refcounted_compacting_allocator_top.sv]
// Insert with room writes a new slot; a request with a null handle skips the search;
// retrieve/add/drop read the used slots in order until the handle matches, else NOT_FOUND.
// Without room, insert compacts every used slot once and retries; still no room gives MEM_FULL.
// One transfer at a time: s_ready is high only in idle, which is reentered as m_valid rises.
// Reset: aresetn synchronous active low; clears live bits, counters, next handle to 1.
// Slot RAM contents are not cleared; entries are used only while live.
module refcounted_compacting_allocator_top #(
    parameter int MAX_SLOTS = 64
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  rca_pkg::req_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output rca_pkg::rsp_t   m_data
);
    import rca_pkg::*;
    `include "refcounted_compacting_allocator_top_defines.svh"

    localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam logic [CW-1:0] SLOTS_C = CW'(MAX_SLOTS);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_INS    = 3'd1;
    localparam logic [2:0] S_PK_RD  = 3'd2;
    localparam logic [2:0] S_PK_WR  = 3'd3;
    localparam logic [2:0] S_PK_END = 3'd4;
    localparam logic [2:0] S_FD_RD  = 3'd5;
    localparam logic [2:0] S_FD_CHK = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]             state_reg;
    req_t                   req_reg;
    logic [MAX_SLOTS-1:0]   live_reg;
    logic [CW-1:0]          slots_used_reg;
    logic [CW-1:0]          live_total_reg;
    logic [ADDR_W-1:0]      next_free_reg;
    logic [HANDLE_BITS:0]   next_id_reg;
    logic                   region_reg;
    logic                   comp_reg;
    logic [CW-1:0]          idx_reg;      // pack source / search index
    logic [CW-1:0]          dst_reg;      // pack destination
    logic [ADDR_W-1:0]      pk_addr_reg;  // running packed address
    logic [1:0]             status_reg;
    logic [HANDLE_BITS-1:0] newh_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic                   m_valid_reg;
    rsp_t                   m_data_reg;

    alu_ctl_t               alu_ctl;
    logic [ALU_W-1:0]       alu_y;
    logic                   ram_we;
    logic [SW-1:0]          ram_waddr;
    slot_entry_t            ram_wdata;
    slot_entry_t            ram_rdata;

    logic                   exhausted;
    logic                   fits;
    logic                   match;
    logic [REFS_W-1:0]      refs_new;
    logic [CW+6:0]          live_ext;

    rca_alu u_alu (
        .ctl (alu_ctl),
        .y   (alu_y)
    );

    rca_slot_ram #(
        .DEPTH (MAX_SLOTS),
        .AW    (SW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg[SW-1:0]),
        .rdata (ram_rdata)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign exhausted = next_id_reg[HANDLE_BITS];
    // room test: slot free and next_free + size below the byte space
    assign fits  = (slots_used_reg < SLOTS_C) && (alu_y < ALU_W'(MEM_BYTES));
    assign match = live_reg[idx_reg[SW-1:0]] && (ram_rdata.handle == req_reg.handle);
    assign live_ext = {7'd0, live_total_reg};

    // shared adder: room test, packed address, ref count step
    always_comb begin
        alu_ctl.op = ALU_ADD;
        alu_ctl.a  = ALU_W'(next_free_reg);
        alu_ctl.b  = ALU_W'(req_reg.size);
        case (state_reg)
            S_PK_WR: begin
                alu_ctl.a = ALU_W'(pk_addr_reg);
                alu_ctl.b = ALU_W'(ram_rdata.size);
            end
            S_FD_CHK: begin
                alu_ctl.a  = ALU_W'(ram_rdata.refs);
                alu_ctl.b  = ALU_W'(1);
                alu_ctl.op = (req_reg.req_type == REQ_ADD) ? ALU_ADD : ALU_SUB;
            end
            default: ;
        endcase
    end

    // ref count step, saturating at both ends
    always_comb begin
        refs_new = ram_rdata.refs;
        if (state_reg == S_FD_CHK) begin
            if (req_reg.req_type == REQ_ADD) begin
                if (ram_rdata.refs != REFS_MAX) refs_new = alu_y[REFS_W-1:0];
            end else if (ram_rdata.refs != '0) begin
                refs_new = alu_y[REFS_W-1:0];
            end
        end
    end

    // slot RAM write port
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg[SW-1:0];
        ram_wdata = ram_rdata;
        case (state_reg)
            S_INS: begin
                ram_waddr        = slots_used_reg[SW-1:0];
                ram_wdata.handle = next_id_reg[HANDLE_BITS-1:0];
                ram_wdata.start  = next_free_reg;
                ram_wdata.size   = req_reg.size;
                ram_wdata.refs   = REFS_W'(1);
                ram_we           = !exhausted && fits;
            end
            S_PK_WR: begin
                ram_waddr       = dst_reg[SW-1:0];
                ram_wdata.start = pk_addr_reg;
                ram_we          = live_reg[idx_reg[SW-1:0]];
            end
            S_FD_CHK: begin
                ram_wdata.refs = refs_new;
                ram_we         = match && (req_reg.req_type != REQ_RETRIEVE);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            live_reg       <= '0;
            slots_used_reg <= '0;
            live_total_reg <= '0;
            next_free_reg  <= '0;
            next_id_reg    <= (HANDLE_BITS+1)'(1);
            region_reg     <= 1'b0;
            comp_reg       <= 1'b0;
            idx_reg        <= '0;
            dst_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            // S_DONE drives m_valid itself
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        req_reg    <= s_data;
                        comp_reg   <= 1'b0;
                        newh_reg   <= '0;
                        addr_reg   <= '0;
                        idx_reg    <= '0;
                        if (s_data.req_type == REQ_INSERT) begin
                            status_reg <= ST_OK;
                            state_reg  <= S_INS;
                        end else if (s_data.handle == '0) begin
                            status_reg <= ST_NOT_FOUND;
                            state_reg  <= S_DONE;
                        end else begin
                            status_reg <= ST_OK;
                            state_reg  <= S_FD_RD;
                        end
                    end
                end
                S_INS: begin
                    if (exhausted) begin
                        status_reg <= ST_EXHAUSTED;
                        state_reg  <= S_DONE;
                    end else if (fits) begin
                        live_reg[slots_used_reg[SW-1:0]] <= 1'b1;
                        slots_used_reg <= slots_used_reg + 1'b1;
                        live_total_reg <= live_total_reg + 1'b1;
                        next_free_reg  <= alu_y[ADDR_W-1:0];
                        next_id_reg    <= next_id_reg + 1'b1;
                        newh_reg       <= next_id_reg[HANDLE_BITS-1:0];
                        addr_reg       <= next_free_reg;
                        state_reg      <= S_DONE;
                    end else if (comp_reg) begin
                        status_reg <= ST_MEM_FULL;
                        state_reg  <= S_DONE;
                    end else begin
                        idx_reg     <= '0;
                        dst_reg     <= '0;
                        pk_addr_reg <= '0;
                        state_reg   <= S_PK_RD;
                    end
                end
                S_PK_RD: begin
                    state_reg <= (idx_reg < slots_used_reg) ? S_PK_WR : S_PK_END;
                end
                S_PK_WR: begin
                    if (live_reg[idx_reg[SW-1:0]]) begin
                        dst_reg     <= dst_reg + 1'b1;
                        pk_addr_reg <= alu_y[ADDR_W-1:0];
                    end
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_PK_RD;
                end
                S_PK_END: begin
                    // packed entries occupy the lowest slots
                    for (int i = 0; i < MAX_SLOTS; i++) begin
                        live_reg[i] <= (CW'(i) < dst_reg);
                    end
                    slots_used_reg <= dst_reg;
                    live_total_reg <= dst_reg;
                    next_free_reg  <= pk_addr_reg;
                    region_reg     <= ~region_reg;
                    comp_reg       <= 1'b1;
                    state_reg      <= S_INS;
                end
                S_FD_RD: begin
                    if (idx_reg < slots_used_reg) begin
                        state_reg <= S_FD_CHK;
                    end else begin
                        status_reg <= ST_NOT_FOUND;
                        state_reg  <= S_DONE;
                    end
                end
                S_FD_CHK: begin
                    if (match) begin
                        if (req_reg.req_type == REQ_RETRIEVE) begin
                            addr_reg <= ram_rdata.start;
                        end else if (req_reg.req_type == REQ_DROP && refs_new == '0) begin
                            live_reg[idx_reg[SW-1:0]] <= 1'b0;
                            if (live_total_reg != '0) begin
                                live_total_reg <= live_total_reg - 1'b1;
                            end
                        end
                        state_reg <= S_DONE;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_FD_RD;
                    end
                end
                S_DONE: begin
                    // output register; hold until the previous transfer drains
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg             <= 1'b1;
                        m_data_reg.status       <= status_reg;
                        m_data_reg.new_handle   <= newh_reg;
                        m_data_reg.address      <= addr_reg;
                        m_data_reg.region       <= region_reg;
                        m_data_reg.compacted    <= comp_reg;
                        m_data_reg.live_objects <= live_ext[6:0];
                        m_data_reg.free_index   <= next_free_reg;
                        state_reg               <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `RCA_ASSERT_IMP(a_live_le_used, 1'b1, live_total_reg <= slots_used_reg)
    `RCA_ASSERT_NXT(a_one_at_a_time, s_valid && s_ready, !s_ready)
    `RCA_ASSERT_IMP(a_ok_insert_handle, m_valid && m_data.status == ST_OK && m_data.new_handle != '0, m_data.address <= m_data.free_index)
endmodule

[design/rca_alu.sv]
module rca_alu (
    input  rca_pkg::alu_ctl_t           ctl,
    output logic [rca_pkg::ALU_W-1:0]   y
);
    import rca_pkg::*;

    always_comb begin
        if (ctl.op == ALU_SUB) begin
            y = ctl.a - ctl.b;
        end else begin
            y = ctl.a + ctl.b;
        end
    end
endmodule

[design/rca_slot_ram.sv]
module rca_slot_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                   aclk,
    input  logic                   we,
    input  logic [AW-1:0]          waddr,
    input  rca_pkg::slot_entry_t   wdata,
    input  logic [AW-1:0]          raddr,
    output rca_pkg::slot_entry_t   rdata
);
    import rca_pkg::*;

    slot_entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
